>>> rtl/core/htcfp_pkg.sv
// types, constants and helpers for the hex text frame parser
package htcfp_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned IdWidth   = 32;
   localparam int unsigned DataWidth = 64;
   localparam int unsigned DlcWidth  = 4;
   localparam int unsigned MaxBytes  = 8;

   localparam logic [CharWidth-1:0] SepReset  = 8'd44;
   localparam logic [CharWidth-1:0] TermReset = 8'd10;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_SEPARATOR  = 1'b0,
      CSR_TERMINATOR = 1'b1
   } csr_index_type;

   // field position within one line
   typedef enum logic [2:0] {
      FIELD_ID   = 3'd0,
      FIELD_RTR  = 3'd1,
      FIELD_IDE  = 3'd2,
      FIELD_DATA = 3'd3,
      FIELD_TAIL = 3'd4
   } field_type;

   // hex digit value, anything else reads as zero
   function automatic logic [3:0] hex_value(input logic [CharWidth-1:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
         v = c[3:0];
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         // low nibble of a..f / A..F is 1..6
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

>>> rtl/core/hex_text_can_frame_parser.sv
// hex text frame parser top level: input register, parse state, result register
// Takes one ASCII character per beat on req_ and gives one parsed frame on rsp_
// for each terminator character. A line is ID,RTR,IDE,DATA in hex digit pairs;
// non-hex characters count as digit 0, missing fields read as zero, data beyond
// eight bytes is dropped and flagged in rsp_data_truncated, and a line longer
// than LINE_LIMIT characters restarts parsing. One character is accepted every
// clock cycle while no terminator waits on a stalled result. A terminator beat
// is registered in the input register and moves into the result register once
// that is free, so its frame reaches rsp_ through both registers. A stalled
// result holds back a following terminator and the characters behind it; other
// characters keep flowing. Separator and terminator codes are set through csr_
// only while the block is idle, which the user must ensure; it is not enforced.
module hex_text_can_frame_parser
   import htcfp_pkg::*;
#(
   parameter int unsigned LINE_LIMIT = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CharWidth-1:0] req_rx_char,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IdWidth-1:0]   rsp_frame_id,
   output logic                 rsp_frame_rtr,
   output logic                 rsp_frame_ide,
   output logic [DlcWidth-1:0]  rsp_frame_dlc,
   output logic [DataWidth-1:0] rsp_frame_data,
   output logic                 rsp_data_truncated,
   input  logic                 csr_write,
   input  csr_index_type        csr_index,
   input  logic [CharWidth-1:0] csr_wdata
);

   localparam int unsigned LenWidth = $clog2(LINE_LIMIT + 1);

   logic [CharWidth-1:0] sep_ff, term_ff;

   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_char_ff;

   field_type            field_ff, field_in;
   logic                 phase_ff, phase_in;
   logic [3:0]           high_ff, high_in;
   logic [IdWidth-1:0]   id_ff, id_in;
   logic [7:0]           rtr_ff, rtr_in;
   logic [7:0]           ide_ff, ide_in;
   logic [DataWidth-1:0] data_ff, data_in;
   logic [DlcWidth-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [LenWidth-1:0]  len_ff, len_in;

   logic                 out_valid_ff;
   logic [IdWidth-1:0]   out_id_ff;
   logic                 out_rtr_ff, out_ide_ff, out_ovf_ff;
   logic [DlcWidth-1:0]  out_dlc_ff;
   logic [DataWidth-1:0] out_data_ff;

   logic is_term, out_free, fire, emit;

   assign is_term   = (in_char_ff == term_ff);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!is_term || out_free);
   assign emit      = fire && is_term;
   assign req_stall = in_valid_ff && !fire;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff  <= SepReset;
         term_ff <= TermReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SEPARATOR:  sep_ff  <= csr_wdata;
            CSR_TERMINATOR: term_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_rx_char;
      end
   end

   // parse step for the character in the input register
   always_comb begin
      logic        restart;
      logic        store_en;
      logic [7:0]  byte_val;
      logic [3:0]  digit;

      restart  = (len_ff >= LenWidth'(LINE_LIMIT));
      digit    = hex_value(in_char_ff);

      field_in = restart ? FIELD_ID : field_ff;
      phase_in = restart ? 1'b0 : phase_ff;
      high_in  = restart ? 4'd0 : high_ff;
      id_in    = restart ? '0 : id_ff;
      rtr_in   = restart ? 8'd0 : rtr_ff;
      ide_in   = restart ? 8'd0 : ide_ff;
      data_in  = restart ? '0 : data_ff;
      count_in = restart ? '0 : count_ff;
      ovf_in   = restart ? 1'b0 : ovf_ff;
      len_in   = (restart ? '0 : len_ff) + LenWidth'(1);

      // terminator in mid-pair completes the byte with a zero low nibble
      store_en = phase_in;
      byte_val = {high_in, (is_term ? 4'd0 : digit)};

      if (store_en) begin
         case (field_in)
            FIELD_ID:  id_in  = {id_in[IdWidth-9:0], byte_val};
            FIELD_RTR: rtr_in = byte_val;
            FIELD_IDE: ide_in = byte_val;
            FIELD_DATA: begin
               if (count_in < DlcWidth'(MaxBytes)) begin
                  data_in[(3'd7 - count_in[2:0]) * 8 +: 8] = byte_val;
                  count_in = count_in + DlcWidth'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (!is_term) begin
         if (!phase_in) begin
            if (in_char_ff == sep_ff) begin
               if (field_in != FIELD_TAIL) begin
                  field_in = field_type'(3'(field_in) + 3'd1);
               end
            end else begin
               high_in  = digit;
               phase_in = 1'b1;
            end
         end else begin
            phase_in = 1'b0;
         end
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= FIELD_ID;
         phase_ff <= 1'b0;
         high_ff  <= 4'd0;
         id_ff    <= '0;
         rtr_ff   <= 8'd0;
         ide_ff   <= 8'd0;
         data_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         len_ff   <= '0;
      end else if (fire) begin
         if (is_term) begin
            field_ff <= FIELD_ID;
            phase_ff <= 1'b0;
            high_ff  <= 4'd0;
            id_ff    <= '0;
            rtr_ff   <= 8'd0;
            ide_ff   <= 8'd0;
            data_ff  <= '0;
            count_ff <= '0;
            ovf_ff   <= 1'b0;
            len_ff   <= '0;
         end else begin
            field_ff <= field_in;
            phase_ff <= phase_in;
            high_ff  <= high_in;
            id_ff    <= id_in;
            rtr_ff   <= rtr_in;
            ide_ff   <= ide_in;
            data_ff  <= data_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
            len_ff   <= len_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_id_ff   <= id_in;
         out_rtr_ff  <= (rtr_in != 8'd0);
         out_ide_ff  <= (ide_in != 8'd0);
         out_dlc_ff  <= count_in;
         out_data_ff <= data_in;
         out_ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_id       = out_id_ff;
   assign rsp_frame_rtr      = out_rtr_ff;
   assign rsp_frame_ide      = out_ide_ff;
   assign rsp_frame_dlc      = out_dlc_ff;
   assign rsp_frame_data     = out_data_ff;
   assign rsp_data_truncated = out_ovf_ff;

endmodule
